@@ design/obb_point_query_top_macros.svh @@
// assertion macros for the oriented-box query unit
`ifndef OBB_POINT_QUERY_TOP_MACROS_SVH
`define OBB_POINT_QUERY_TOP_MACROS_SVH

// property checked outside reset
`define OBBPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define OBBPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/obbpq_pkg.sv @@
// shared types and constants of the oriented-box query unit
package obbpq_pkg;

    localparam int COORD_WIDTH_DEF    = 16;
    localparam int AXIS_FRAC_BITS_DEF = 14;
    localparam int CFG_W              = 48;
    localparam int CFG_IDX_W          = 3;
    // register stages from accept to result strobe
    localparam int PIPE_STAGES        = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER = 3'd0,
        CFG_HALF   = 3'd1,
        CFG_AXIS_U = 3'd2,
        CFG_AXIS_V = 3'd3,
        CFG_AXIS_W = 3'd4
    } t_cfg_idx;

endpackage

@@ design/obb_point_query_top.sv @@
// oriented-box closest point / support vertex query pipeline
//
// Oriented-box query unit. The box (centre, half-extents along u,v,w and the
// three axis vectors) lives in five 48-bit registers written through the
// i_cfg_we / i_cfg_idx / i_cfg_data port; write them only while no item is in
// flight. An item is taken at a clock edge where start is high and busy is
// low. busy is high only in the first cycle after reset; from then on the unit
// takes one item every cycle. Every item gives exactly one result, shown on
// o_rx/o_ry/o_rz/o_inside_res/o_saturated for one cycle with o_valid high;
// the receiver cannot hold it off, so it must take it in that cycle. Each item
// passes through the seven-stage pipeline: offset, axis products, projection
// sums, round and clamp, back-products, back-sums, round and saturate. Mode 0
// gives the closest box point of the query point and an inside flag (boundary
// counts as inside); mode 1 gives the box vertex farthest along the query
// direction (ties go to the minus side) and inside_res is 0. All coordinates
// are signed Q8.8 saturated to COORD_WIDTH bits; rounding adds half an lsb
// and floors.
module obb_point_query_top
    import obbpq_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_qx,
    input  logic signed [COORD_WIDTH-1:0] i_qy,
    input  logic signed [COORD_WIDTH-1:0] i_qz,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_rx,
    output logic signed [COORD_WIDTH-1:0] o_ry,
    output logic signed [COORD_WIDTH-1:0] o_rz,
    output logic                          o_inside_res,
    output logic                          o_saturated
);

    localparam int CW   = COORD_WIDTH;
    localparam int AF   = AXIS_FRAC_BITS;
    localparam int AW   = AF + 2;                 // axis component width
    localparam int VW   = CW + 1;                 // offset / clamped projection
    localparam int PW   = VW + AW;                // one product
    localparam int NW   = PW + 2;                 // sum of up to four terms
    localparam int SW   = (NW > 64) ? 64 : NW;    // sums wrap at 64 bits
    localparam int RW   = (SW + 1 > 64) ? 64 : SW + 1;
    localparam int TW   = RW - AF;                // width after rounding shift
    localparam int HW   = (TW > VW) ? TW + 1 : VW + 1;
    localparam int CPW  = (3 * CW > CFG_W) ? 3 * CW : CFG_W;
    localparam int APW  = (3 * AW > CFG_W) ? 3 * AW : CFG_W;
    localparam int NSTG = PIPE_STAGES;

    localparam logic [CFG_W-1:0] AXIS_U_RST = CFG_W'(1) << AF;
    localparam logic [CFG_W-1:0] AXIS_V_RST = AXIS_U_RST << AW;
    localparam logic [CFG_W-1:0] AXIS_W_RST = AXIS_V_RST << AW;
    localparam logic signed [RW-1:0] HALF_LSB = RW'(1) << (AF - 1);
    localparam logic signed [TW-1:0] SAT_MAX  = TW'({1'b0, {(CW - 1){1'b1}}});
    localparam logic signed [TW-1:0] SAT_MIN  = -SAT_MAX - TW'(1);

    // configuration registers
    logic [CFG_W-1:0] r_center, r_half, r_axis_u, r_axis_v, r_axis_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_half   <= '0;
            r_axis_u <= AXIS_U_RST;
            r_axis_v <= AXIS_V_RST;
            r_axis_w <= AXIS_W_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER: r_center <= i_cfg_data;
                CFG_HALF:   r_half   <= i_cfg_data;
                CFG_AXIS_U: r_axis_u <= i_cfg_data;
                CFG_AXIS_V: r_axis_v <= i_cfg_data;
                CFG_AXIS_W: r_axis_w <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // unpacked box fields; bits beyond the register read as zero
    logic [CPW-1:0]          cen_ext, half_ext;
    logic [APW-1:0]          ax_ext [3];
    logic signed [CW-1:0]    cen [3];
    logic [CW-1:0]           half [3];
    logic signed [AW-1:0]    ax [3][3];
    logic signed [CW-1:0]    q_in [3];

    assign cen_ext   = CPW'(r_center);
    assign half_ext  = CPW'(r_half);
    assign ax_ext[0] = APW'(r_axis_u);
    assign ax_ext[1] = APW'(r_axis_v);
    assign ax_ext[2] = APW'(r_axis_w);
    assign q_in[0]   = i_qx;
    assign q_in[1]   = i_qy;
    assign q_in[2]   = i_qz;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            cen[j]  = cen_ext[j*CW +: CW];
            half[j] = half_ext[j*CW +: CW];
            for (int i = 0; i < 3; i++) begin
                ax[i][j] = ax_ext[i][j*AW +: AW];
            end
        end
    end

    // handshake and valid chain
    logic            r_busy;
    logic [NSTG-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[NSTG-2:0], start & ~r_busy};
        end
    end

    assign busy = r_busy;

    // stage 1: offset from centre (mode 0) or raw direction (mode 1)
    logic signed [VW-1:0] r_v [3], n_v [3];
    logic [2:0]           r_md;    // mode through stages 1 to 3

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_v[j] = i_mode ? VW'(q_in[j]) : VW'(q_in[j]) - VW'(cen[j]);
        end
    end

    // stage 2: projection products onto each axis
    logic signed [PW-1:0] r_p1 [3][3], n_p1 [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_p1[i][j] = PW'(r_v[j]) * PW'(ax[i][j]);
            end
        end
    end

    // stage 3: dot products
    logic signed [SW-1:0] r_s [3], n_s [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s[i] = SW'(r_p1[i][0]) + SW'(r_p1[i][1]) + SW'(r_p1[i][2]);
        end
    end

    // stage 4: round and clamp to the half-extent, or pick the support side
    logic signed [VW-1:0] r_t [3], n_t [3];
    logic                 n_ins;
    logic [3:0]           r_ins;   // inside flag through stages 4 to 7

    always_comb begin
        logic signed [RW-1:0] rnd;
        logic signed [TW-1:0] proj;
        logic signed [HW-1:0] pe, he;
        n_ins = ~r_md[2];
        for (int i = 0; i < 3; i++) begin
            rnd  = RW'(r_s[i]) + HALF_LSB;
            proj = TW'(rnd >>> AF);
            pe   = HW'(proj);
            he   = $signed(HW'(half[i]));
            if (r_md[2]) begin
                n_t[i] = (r_s[i] > SW'(0)) ? VW'(he) : VW'(-he);
            end else if (pe > he) begin
                n_t[i] = VW'(he);
                n_ins  = 1'b0;
            end else if (pe < -he) begin
                n_t[i] = VW'(-he);
                n_ins  = 1'b0;
            end else begin
                n_t[i] = VW'(pe);
            end
        end
    end

    // stage 5: back-products along the axes
    logic signed [PW-1:0] r_p2 [3][3], n_p2 [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_p2[i][j] = PW'(r_t[i]) * PW'(ax[i][j]);
            end
        end
    end

    // stage 6: centre plus the summed back-projections
    logic signed [SW-1:0] r_acc [3], n_acc [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_acc[j] = (SW'(cen[j]) <<< AF) + SW'(r_p2[0][j])
                     + SW'(r_p2[1][j]) + SW'(r_p2[2][j]);
        end
    end

    // stage 7: round back to q8.8 and saturate
    logic signed [CW-1:0] r_r [3], n_r [3];
    logic                 r_sat, n_sat;

    always_comb begin
        logic signed [RW-1:0] rnd;
        logic signed [TW-1:0] val;
        n_sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            rnd = RW'(r_acc[j]) + HALF_LSB;
            val = TW'(rnd >>> AF);
            if (val > SAT_MAX) begin
                n_r[j] = CW'(SAT_MAX);
                n_sat  = 1'b1;
            end else if (val < SAT_MIN) begin
                n_r[j] = CW'(SAT_MIN);
                n_sat  = 1'b1;
            end else begin
                n_r[j] = CW'(val);
            end
        end
    end

    // datapath registers advance every cycle; r_vld says which hold items
    always_ff @(posedge i_clk) begin
        r_md  <= {r_md[1:0], i_mode};
        r_ins <= {r_ins[2:0], n_ins};
        r_sat <= n_sat;
        r_v   <= n_v;
        r_p1  <= n_p1;
        r_s   <= n_s;
        r_t   <= n_t;
        r_p2  <= n_p2;
        r_acc <= n_acc;
        r_r   <= n_r;
    end

    assign o_valid      = r_vld[NSTG-1];
    assign o_rx         = r_r[0];
    assign o_ry         = r_r[1];
    assign o_rz         = r_r[2];
    assign o_inside_res = r_ins[3];
    assign o_saturated  = r_sat;

endmodule

@@ design/obbpq_checker.sv @@
// port-level assertions for the oriented-box query unit, bound to the top level
`include "obb_point_query_top_macros.svh"

module obbpq_checker
    import obbpq_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_mode,
    input logic                          o_valid,
    input logic signed [COORD_WIDTH-1:0] o_rx,
    input logic signed [COORD_WIDTH-1:0] o_ry,
    input logic signed [COORD_WIDTH-1:0] o_rz,
    input logic                          o_inside_res,
    input logic                          o_saturated
);

    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    // every accepted item comes out of the pipeline with o_valid high
    `OBBPQ_ASSERT(a_latency, (start && !busy) |-> ##PIPE_STAGES o_valid, "item result missing")

    // no result without an item accepted at the matching edge
    `OBBPQ_ASSERT(a_no_spurious, o_valid |-> $past(start && !busy, PIPE_STAGES), "result without item")

    // support-vertex queries never report inside
    `OBBPQ_ASSERT(a_mode1_outside, (o_valid && $past(i_mode && start && !busy, PIPE_STAGES)) |-> !o_inside_res, "inside flag in mode 1")

    // saturation flag implies some component sits at a range limit
    `OBBPQ_ASSERT(a_sat_limit, (o_valid && o_saturated) |-> (o_rx == CMAX || o_rx == CMIN || o_ry == CMAX || o_ry == CMIN || o_rz == CMAX || o_rz == CMIN), "saturation flag without clipped value")

    // first cycle after reset refuses items
    `OBBPQ_ASSERT_ALWAYS(a_busy_after_reset, !i_rst_n |=> busy, "busy low right after reset")

endmodule

bind obb_point_query_top obbpq_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_obbpq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_mode       (i_mode),
    .o_valid      (o_valid),
    .o_rx         (o_rx),
    .o_ry         (o_ry),
    .o_rz         (o_rz),
    .o_inside_res (o_inside_res),
    .o_saturated  (o_saturated)
);
